### hw/rtl/bcta_pkg.sv
// bcta_pkg: types, constants and trit-level bit functions of the ternary alu
// used by bcta_decode, bcta_stage, bcta_result, bcta_checker and binary_coded_ternary_alu
// no dependencies
`default_nettype none

package bcta_pkg;

  localparam int unsigned TRITS    = 32;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned OP_W     = 4;

  // low 2*TRITS bits of a 64-bit word
  localparam logic [WORD_W-1:0] WORD_MASK = {WORD_W{1'b1}} >> (WORD_W - 2 * TRITS);

  localparam logic [WORD_W-1:0] ODD_BITS  = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [WORD_W-1:0] EVEN_BITS = 64'h5555_5555_5555_5555;

  // carry chain: y loses one low trit per round, so TRITS rounds always finish
  localparam int unsigned ADD_ROUNDS       = TRITS;
  localparam int unsigned ROUNDS_PER_STAGE = 4;
  localparam int unsigned STAGES_PER_PHASE =
    (ADD_ROUNDS + ROUNDS_PER_STAGE - 1) / ROUNDS_PER_STAGE;
  localparam int unsigned ADD_STAGES       = 2 * STAGES_PER_PHASE;

  // ternary to binary folding, one fold in each of the first CONV_STEPS stages
  localparam int unsigned CONV_STEPS = 5;
  localparam int unsigned CONV_SEL_W = 3;
  localparam logic [31:0] CONV_MUL [CONV_STEPS] = '{
    32'(64'd4 - 64'd3),
    32'(64'd16 - 64'd9),
    32'(64'd256 - 64'd81),
    32'(64'd65536 - 64'd6561),
    32'(64'd4294967296 - 64'd43046721)
  };

  localparam int unsigned SHAMT_W = (TRITS > 1) ? $clog2(TRITS) : 1;

  localparam logic [WORD_W-1:0] CMP_LESS    = 64'd0;
  localparam logic [WORD_W-1:0] CMP_EQUAL   = 64'd1;
  localparam logic [WORD_W-1:0] CMP_GREATER = 64'd3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD        = 4'd0,
    OP_SUB        = 4'd1,
    OP_NOT        = 4'd2,
    OP_XOR        = 4'd3,
    OP_SHL        = 4'd4,
    OP_SHR        = 4'd5,
    OP_CMP        = 4'd6,
    OP_IS_TRUE    = 4'd7,
    OP_IS_FALSE   = 4'd8,
    OP_IS_UNKNOWN = 4'd9,
    OP_TO_BINARY  = 4'd10
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [WORD_W-1:0] x;     // running sum
    logic [WORD_W-1:0] y;     // running carry
    logic [WORD_W-1:0] lhs;   // shift source, or lhs for the second add of sub
    logic [WORD_W-1:0] conv;  // value being folded to binary
    logic [WORD_W-1:0] res;   // result of the ops computed in decode
  } item_t;

  function automatic logic [WORD_W-1:0] hi_lo_xor(logic [WORD_W-1:0] b);
    return ((b & ODD_BITS) >> 1) ^ b;
  endfunction

  function automatic logic [WORD_W-1:0] unknown_low(logic [WORD_W-1:0] b);
    return hi_lo_xor(b) & EVEN_BITS;
  endfunction

  function automatic logic [WORD_W-1:0] pred_unknown(logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] u;
    u = unknown_low(b);
    return u | (u << 1);
  endfunction

  function automatic logic [WORD_W-1:0] pred_true(logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] t;
    t = b & ODD_BITS;
    return t | (t >> 1);
  endfunction

  function automatic logic [WORD_W-1:0] pred_false(logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] f;
    f = ~b & EVEN_BITS;
    return f | (f << 1);
  endfunction

  function automatic logic [WORD_W-1:0] pred_not_false(logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] n;
    n = b & EVEN_BITS;
    return n | (n << 1);
  endfunction

  function automatic logic [WORD_W-1:0] trit_not(logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] u;
    u = unknown_low(b);
    return (~b ^ (u << 1)) ^ u;
  endfunction

  function automatic logic [WORD_W-1:0] trit_xor(logic [WORD_W-1:0] l, logic [WORD_W-1:0] r);
    logic [WORD_W-1:0] both;
    logic [WORD_W-1:0] keep;
    both = (l & EVEN_BITS) & (r & EVEN_BITS);
    keep = ~(both | (both << 1));
    return ((l ^ r) & keep) | both;
  endfunction

  function automatic logic [WORD_W-1:0] trit_sum(logic [WORD_W-1:0] l, logic [WORD_W-1:0] r);
    logic [WORD_W-1:0] tt;
    logic [WORD_W-1:0] tt_low;
    logic [WORD_W-1:0] u_or;
    logic [WORD_W-1:0] ul;
    logic [WORD_W-1:0] ur;
    logic [WORD_W-1:0] tf;
    tt     = pred_true(l & r);
    tt_low = (tt & ODD_BITS) >> 1;
    u_or   = unknown_low(l | r);
    ul     = pred_unknown(l);
    ur     = pred_unknown(r);
    tf     = ((l ^ EVEN_BITS) ^ (r ^ EVEN_BITS)) & ~(ul | ur);
    return tt_low | u_or | tf | (ul & ur);
  endfunction

  function automatic logic [WORD_W-1:0] trit_carry(logic [WORD_W-1:0] l, logic [WORD_W-1:0] r);
    return pred_not_false(l & r) & pred_true(l | r) & EVEN_BITS;
  endfunction

  // one fold of the conversion: fields never overlap, so each product stays in place
  function automatic logic [WORD_W-1:0] conv_step(logic [WORD_W-1:0] a,
                                                 logic [CONV_SEL_W-1:0] sel);
    logic [WORD_W-1:0] p;
    p = '0;
    unique case (sel)
      3'd0: begin
        for (int j = 0; j < 16; j++) p[4*j +: 4] = 4'(a[4*j+2 +: 2]) * CONV_MUL[0][3:0];
      end
      3'd1: begin
        for (int j = 0; j < 8; j++) p[8*j +: 8] = 8'(a[8*j+4 +: 4]) * CONV_MUL[1][7:0];
      end
      3'd2: begin
        for (int j = 0; j < 4; j++) p[16*j +: 16] = 16'(a[16*j+8 +: 8]) * CONV_MUL[2][15:0];
      end
      3'd3: begin
        for (int j = 0; j < 2; j++) p[32*j +: 32] = 32'(a[32*j+16 +: 16]) * CONV_MUL[3];
      end
      3'd4: begin
        p = 64'(a[63:32]) * 64'(CONV_MUL[4]);
      end
      default: p = '0;
    endcase
    return a - p;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bcta_decode.sv
// bcta_decode: input register stage, ops computed in decode and set-up of the add chain
// depends on bcta_pkg
`default_nettype none

module bcta_decode (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  output logic                            ready_o,
  input  wire logic [bcta_pkg::OP_W-1:0]   operation_i,
  input  wire logic [bcta_pkg::WORD_W-1:0] lhs_operand_i,
  input  wire logic [bcta_pkg::WORD_W-1:0] rhs_operand_i,
  input  wire logic [bcta_pkg::WORD_W-1:0] shift_mask_i,
  output logic                            valid_o,
  input  wire logic                       ready_i,
  output bcta_pkg::item_t                 item_o
);

  logic                      valid_q;
  logic                      en;
  bcta_pkg::item_t           item_d;
  bcta_pkg::item_t           item_q;
  logic [bcta_pkg::WORD_W-1:0] l;
  logic [bcta_pkg::WORD_W-1:0] r;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  assign l = lhs_operand_i & bcta_pkg::WORD_MASK;
  assign r = rhs_operand_i & bcta_pkg::WORD_MASK;

  always_comb begin
    item_d      = '0;
    item_d.op   = bcta_pkg::op_e'(operation_i);
    item_d.lhs  = l;
    item_d.conv = bcta_pkg::hi_lo_xor((item_d.op == bcta_pkg::OP_TO_BINARY) ? l : r);
    unique case (item_d.op)
      bcta_pkg::OP_ADD: begin
        item_d.x = l;
        item_d.y = r;
      end
      bcta_pkg::OP_SUB: begin
        // first add: complement of rhs plus one
        item_d.x = bcta_pkg::trit_not(r) & bcta_pkg::WORD_MASK;
        item_d.y = bcta_pkg::WORD_W'(1);
      end
      bcta_pkg::OP_NOT: item_d.res = bcta_pkg::trit_not(l) & bcta_pkg::WORD_MASK;
      bcta_pkg::OP_XOR: item_d.res = bcta_pkg::trit_xor(l, r) & bcta_pkg::WORD_MASK;
      bcta_pkg::OP_SHR: item_d.lhs = l & shift_mask_i;
      bcta_pkg::OP_CMP: begin
        if (l < r) begin
          item_d.res = bcta_pkg::CMP_LESS;
        end else if (l > r) begin
          item_d.res = bcta_pkg::CMP_GREATER;
        end else begin
          item_d.res = bcta_pkg::CMP_EQUAL;
        end
      end
      bcta_pkg::OP_IS_TRUE:    item_d.res = bcta_pkg::pred_true(l) & bcta_pkg::WORD_MASK;
      bcta_pkg::OP_IS_FALSE:   item_d.res = bcta_pkg::pred_false(l) & bcta_pkg::WORD_MASK;
      bcta_pkg::OP_IS_UNKNOWN: item_d.res = bcta_pkg::pred_unknown(l) & bcta_pkg::WORD_MASK;
      default: item_d.res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bcta_stage.sv
// bcta_stage: one register stage of the carry chain, ROUNDS_PER_STAGE add rounds plus at
// most one conversion fold, picked by conv_sel_i; depends on bcta_pkg
`default_nettype none

module bcta_stage (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  output logic                                ready_o,
  input  wire bcta_pkg::item_t                item_i,
  input  wire logic                           load_i,
  input  wire logic [bcta_pkg::CONV_SEL_W-1:0] conv_sel_i,
  output logic                                valid_o,
  input  wire logic                           ready_i,
  output bcta_pkg::item_t                     item_o
);

  logic            valid_q;
  logic            en;
  bcta_pkg::item_t item_d;
  bcta_pkg::item_t item_q;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    logic [bcta_pkg::WORD_W-1:0] x;
    logic [bcta_pkg::WORD_W-1:0] y;
    logic [bcta_pkg::WORD_W-1:0] c;
    item_d = item_i;
    x      = item_i.x;
    y      = item_i.y;
    c      = '0;
    // start of the second add of a subtract: lhs plus the negated rhs
    if (load_i && (item_i.op == bcta_pkg::OP_SUB)) begin
      x = item_i.lhs;
      y = item_i.x;
    end
    for (int i = 0; i < bcta_pkg::ROUNDS_PER_STAGE; i++) begin
      // a round with no carry left would still disturb the invalid code
      if (y != '0) begin
        c = bcta_pkg::trit_carry(x, y);
        x = bcta_pkg::trit_sum(x, y) & bcta_pkg::WORD_MASK;
        y = (c << 2) & bcta_pkg::WORD_MASK;
      end
    end
    item_d.x    = x;
    item_d.y    = y;
    item_d.conv = bcta_pkg::conv_step(item_i.conv, conv_sel_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bcta_result.sv
// bcta_result: trit shifts, result selection and the output register
// depends on bcta_pkg
`default_nettype none

module bcta_result (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  output logic                            ready_o,
  input  wire bcta_pkg::item_t            item_i,
  output logic                            valid_o,
  input  wire logic                       ready_i,
  output logic [bcta_pkg::WORD_W-1:0]     result_o
);

  logic                          valid_q;
  logic                          en;
  logic [bcta_pkg::WORD_W-1:0]   result_d;
  logic [bcta_pkg::WORD_W-1:0]   result_q;
  logic                          too_far;
  logic [bcta_pkg::SHAMT_W:0]    bit_shift;

  assign en       = !valid_q || ready_i;
  assign ready_o  = en;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  // conv holds the binary trit count once all folds are done
  assign too_far   = item_i.conv >= bcta_pkg::WORD_W'(bcta_pkg::TRITS);
  assign bit_shift = {item_i.conv[bcta_pkg::SHAMT_W-1:0], 1'b0};

  always_comb begin
    unique case (item_i.op)
      bcta_pkg::OP_ADD,
      bcta_pkg::OP_SUB: result_d = item_i.x & bcta_pkg::WORD_MASK;
      bcta_pkg::OP_SHL: begin
        result_d = too_far ? '0 : ((item_i.lhs << bit_shift) & bcta_pkg::WORD_MASK);
      end
      bcta_pkg::OP_SHR: begin
        result_d = too_far ? '0 : ((item_i.lhs >> bit_shift) & bcta_pkg::WORD_MASK);
      end
      bcta_pkg::OP_TO_BINARY: result_d = item_i.conv;
      default: result_d = item_i.res;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      result_q <= result_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/binary_coded_ternary_alu.sv
// binary_coded_ternary_alu: top level of the pipelined binary-coded ternary alu
// depends on bcta_pkg, bcta_decode, bcta_stage and bcta_result
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+------------------------------------
//   in      | in  | in_valid_i / in_ready_o   | operation_i, lhs_operand_i,
//           |     |                           | rhs_operand_i, shift_mask_i
//   out     | out | out_valid_o / out_ready_i | result_word_o
//
// one beat in per cycle while the output is not stalled; every operation passes the decode
// register, 16 carry-chain stages of 4 add rounds each (8 per add, two adds for
// subtract) and the output register
// each stage holds while the stage after it is full and stalled, so bubbles close up
// and a beat is taken while a finished result waits
// reset clears only the valid bits; the data registers are not reset
`default_nettype none

module binary_coded_ternary_alu (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [bcta_pkg::OP_W-1:0]   operation_i,
  input  wire logic [bcta_pkg::WORD_W-1:0] lhs_operand_i,
  input  wire logic [bcta_pkg::WORD_W-1:0] rhs_operand_i,
  input  wire logic [bcta_pkg::WORD_W-1:0] shift_mask_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [bcta_pkg::WORD_W-1:0]     result_word_o
);

  logic            stg_valid [bcta_pkg::ADD_STAGES+1];
  logic            stg_ready [bcta_pkg::ADD_STAGES+1];
  bcta_pkg::item_t stg_item  [bcta_pkg::ADD_STAGES+1];

  bcta_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_valid_i),
    .ready_o       (in_ready_o),
    .operation_i   (operation_i),
    .lhs_operand_i (lhs_operand_i),
    .rhs_operand_i (rhs_operand_i),
    .shift_mask_i  (shift_mask_i),
    .valid_o       (stg_valid[0]),
    .ready_i       (stg_ready[0]),
    .item_o        (stg_item[0])
  );

  for (genvar k = 0; k < bcta_pkg::ADD_STAGES; k++) begin : g_stage
    bcta_stage u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .valid_i    (stg_valid[k]),
      .ready_o    (stg_ready[k]),
      .item_i     (stg_item[k]),
      .load_i     (k == bcta_pkg::STAGES_PER_PHASE),
      .conv_sel_i (bcta_pkg::CONV_SEL_W'((k < bcta_pkg::CONV_STEPS) ? k
                                                                  : bcta_pkg::CONV_STEPS)),
      .valid_o    (stg_valid[k+1]),
      .ready_i    (stg_ready[k+1]),
      .item_o     (stg_item[k+1])
    );
  end

  bcta_result u_result (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (stg_valid[bcta_pkg::ADD_STAGES]),
    .ready_o  (stg_ready[bcta_pkg::ADD_STAGES]),
    .item_i   (stg_item[bcta_pkg::ADD_STAGES]),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (result_word_o)
  );

endmodule

`default_nettype wire

### hw/rtl/bcta_checker.sv
// bcta_checker: port-level assertions for binary_coded_ternary_alu, bound to the top
// depends on bcta_pkg
`default_nettype none

module bcta_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [bcta_pkg::WORD_W-1:0] result_word_o
);

  // no result beat can be pending while reset is held
  a_reset_quiet : assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result beat shown during reset");

  // an empty output register means every stage can move, so input is open
  a_open_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input held off with an empty output register");

  // a stalled result beat holds its value
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_word_o))
    else $error("stalled result beat dropped or changed");

endmodule

bind binary_coded_ternary_alu bcta_checker u_bcta_checker (.*);

`default_nettype wire
